FILE: rtl/voxel_line_occlusion_unit_macros.svh
// assertion macros for the voxel line occlusion unit
// used by the top level only, no other dependencies
`ifndef VOXEL_LINE_OCCLUSION_UNIT_MACROS_SVH
`define VOXEL_LINE_OCCLUSION_UNIT_MACROS_SVH

// same-cycle implication
`define VLO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("voxel line occlusion check failed");

// next-cycle implication
`define VLO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("voxel line occlusion check failed");

`endif

FILE: rtl/vlo_pkg.sv
// shared types for the voxel line occlusion unit
// action codes and command/status structs between controller and datapath, no dependencies
`timescale 1ns / 1ps

package vlo_pkg;

	localparam int VOXEL_W = 6;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} vlo_action_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic wr_read;
		logic wr_write;
		logic setup_a;
		logic setup_b;
		logic walk;
		logic out_load;
	} vlo_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic walk_end;
		logic hit_now;
	} vlo_sts_t;

endpackage

FILE: rtl/vlo_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module vlo_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/vlo_ctrl.sv
// controller state machine of the voxel line occlusion unit
// depends on vlo_pkg for the action codes and the command and status structs
`timescale 1ns / 1ps

module vlo_ctrl import vlo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     action,
	output logic     out_valid,
	input  logic     out_stall,
	input  vlo_sts_t sts,
	output vlo_cmd_t cmd
);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_WR_RD  = 4'd2;
	localparam logic [3:0] ST_WR_WB  = 4'd3;
	localparam logic [3:0] ST_SET_A  = 4'd4;
	localparam logic [3:0] ST_SET_B  = 4'd5;
	localparam logic [3:0] ST_WALK   = 4'd6;
	localparam logic [3:0] ST_DRAIN  = 4'd7;
	localparam logic [3:0] ST_FINISH = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (action == ACT_QUERY) ? ST_SET_A : ST_WR_RD;
				end
			end
			ST_WR_RD: begin
				cmd.wr_read = 1'b1;
				state_d     = ST_WR_WB;
			end
			ST_WR_WB: begin
				cmd.wr_write = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_SET_A: begin
				cmd.setup_a = 1'b1;
				state_d     = ST_SET_B;
			end
			ST_SET_B: begin
				cmd.setup_b = 1'b1;
				state_d     = ST_WALK;
			end
			ST_WALK: begin
				priority if (sts.hit_now) begin
					state_d = ST_FINISH;
				end else if (sts.walk_end) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.walk = 1'b1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/vlo_dp.sv
// datapath of the voxel line occlusion unit: line walker, ram port muxing, result
// depends on vlo_pkg; the voxel ram sits outside and is reached through the ram ports
`timescale 1ns / 1ps

module vlo_dp import vlo_pkg::*; #(
	parameter int GRID_BITS   = 6,
	parameter int COORD_WIDTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vlo_cmd_t                      cmd,
	output vlo_sts_t                      sts,
	input  logic [VOXEL_W-1:0]            voxel_x,
	input  logic [VOXEL_W-1:0]            voxel_y,
	input  logic [VOXEL_W-1:0]            voxel_z,
	input  logic                          voxel_value,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] start_z,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] end_z,
	output logic                          blocked,
	output logic                          ram_we,
	output logic [2*GRID_BITS-1:0]        ram_waddr,
	output logic [(1<<GRID_BITS)-1:0]     ram_wdata,
	output logic [2*GRID_BITS-1:0]        ram_raddr,
	input  logic [(1<<GRID_BITS)-1:0]     ram_rdata
);

	localparam int GB    = GRID_BITS;
	localparam int CW    = COORD_WIDTH;
	localparam int SPAN  = 1 << GB;
	localparam int ROW_W = 2 * GB;

	function automatic logic [CW:0] absdiff(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		logic signed [CW:0] d;
		logic signed [CW:0] n;
		d = $signed({b[CW-1], b}) - $signed({a[CW-1], a});
		n = -d;
		// top bit: end below start
		return {d[CW], (d[CW] ? n[CW-1:0] : d[CW-1:0])};
	endfunction

	function automatic logic ingrid(input logic signed [CW-1:0] c);
		return !c[CW-1] && (($unsigned(c) >> GB) == '0);
	endfunction

	// write word
	logic [GB-1:0]            wx_q, wy_q, wz_q;
	logic                     wval_q, wok_q;
	logic [SPAN-1:0]          row_mod;

	// raw query endpoints and deltas
	logic signed [CW-1:0]     x0_q, y0_q, z0_q, x1_q, y1_q, z1_q;
	logic [CW-1:0]            adx_q, ady_q, adz_q;
	logic                     nx_q, ny_q, nz_q;
	logic [CW:0]              dfx, dfy, dfz;

	// walker in swapped frame
	logic signed [CW-1:0]     x_q, y_q, z_q, xe_q;
	logic [CW-1:0]            dx_q, dy_q, dz_q;
	logic signed [CW:0]       drxy_q, drxz_q;
	logic                     stx_q, sty_q, stz_q, sxy_q, sxz_q;

	// setup_b swap results
	logic                     sxy, sxz;
	logic [CW-1:0]            ax1, ay1, dx_n, dz_n;
	logic signed [CW-1:0]     xa0, ya0, xa1;
	logic                     nxa, nya;

	// walker step results
	logic signed [CW:0]       txy, txz;
	logic signed [CW-1:0]     ca, cc, cx, cy, cz;

	logic                     vld_s1, in_s1;
	logic [GB-1:0]            cx_s1;
	logic                     hit_q, blocked_q;
	logic [ROW_W-1:0]         clr_q;

	assign dfx = absdiff(x0_q, x1_q);
	assign dfy = absdiff(y0_q, y1_q);
	assign dfz = absdiff(z0_q, z1_q);

	always_comb begin
		sxy  = ady_q > adx_q;
		ax1  = sxy ? ady_q : adx_q;
		ay1  = sxy ? adx_q : ady_q;
		xa0  = sxy ? y0_q : x0_q;
		ya0  = sxy ? x0_q : y0_q;
		xa1  = sxy ? y1_q : x1_q;
		nxa  = sxy ? ny_q : nx_q;
		nya  = sxy ? nx_q : ny_q;
		sxz  = adz_q > ax1;
		dx_n = sxz ? adz_q : ax1;
		dz_n = sxz ? ax1 : adz_q;
	end

	// map the walker position back to grid axes
	always_comb begin
		ca = sxz_q ? z_q : x_q;
		cc = sxz_q ? x_q : z_q;
		cx = sxy_q ? y_q : ca;
		cy = sxy_q ? ca : y_q;
		cz = cc;
	end

	assign txy = drxy_q - $signed({1'b0, dy_q});
	assign txz = drxz_q - $signed({1'b0, dz_q});

	always_comb begin
		row_mod         = ram_rdata;
		row_mod[wx_q]   = wval_q;
	end

	assign ram_we    = cmd.clear || (cmd.wr_write && wok_q);
	assign ram_waddr = cmd.clear ? clr_q : {wz_q, wy_q};
	assign ram_wdata = cmd.clear ? '0 : row_mod;
	assign ram_raddr = cmd.wr_read ? {wz_q, wy_q} : {GB'($unsigned(cz)), GB'($unsigned(cy))};

	assign sts.clr_last = &clr_q;
	assign sts.walk_end = (x_q == xe_q);
	assign sts.hit_now  = vld_s1 && in_s1 && ram_rdata[cx_s1];
	assign blocked      = blocked_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			vld_s1 <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + ROW_W'(1);
			end
			vld_s1 <= cmd.walk;
			if (cmd.setup_b) begin
				hit_q <= 1'b0;
			end else if (sts.hit_now) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wx_q   <= GB'(voxel_x);
			wy_q   <= GB'(voxel_y);
			wz_q   <= GB'(voxel_z);
			wok_q  <= ((voxel_x >> GB) == '0) && ((voxel_y >> GB) == '0)
				&& ((voxel_z >> GB) == '0);
			wval_q <= voxel_value;
			x0_q   <= start_x;
			y0_q   <= start_y;
			z0_q   <= start_z;
			x1_q   <= end_x;
			y1_q   <= end_y;
			z1_q   <= end_z;
		end
		if (cmd.setup_a) begin
			adx_q <= dfx[CW-1:0];
			ady_q <= dfy[CW-1:0];
			adz_q <= dfz[CW-1:0];
			nx_q  <= dfx[CW];
			ny_q  <= dfy[CW];
			nz_q  <= dfz[CW];
		end
		if (cmd.setup_b) begin
			sxy_q  <= sxy;
			sxz_q  <= sxz;
			x_q    <= sxz ? z0_q : xa0;
			z_q    <= sxz ? xa0 : z0_q;
			y_q    <= ya0;
			xe_q   <= sxz ? z1_q : xa1;
			dx_q   <= dx_n;
			dy_q   <= ay1;
			dz_q   <= dz_n;
			stx_q  <= sxz ? nz_q : nxa;
			stz_q  <= sxz ? nxa : nz_q;
			sty_q  <= nya;
			drxy_q <= $signed({2'b00, dx_n[CW-1:1]});
			drxz_q <= $signed({2'b00, dx_n[CW-1:1]});
		end
		if (cmd.walk) begin
			cx_s1 <= GB'($unsigned(cx));
			in_s1 <= ingrid(cx) && ingrid(cy) && ingrid(cz);
			x_q   <= stx_q ? x_q - CW'(1) : x_q + CW'(1);
			if (txy[CW]) begin
				y_q    <= sty_q ? y_q - CW'(1) : y_q + CW'(1);
				drxy_q <= txy + $signed({1'b0, dx_q});
			end else begin
				drxy_q <= txy;
			end
			if (txz[CW]) begin
				z_q    <= stz_q ? z_q - CW'(1) : z_q + CW'(1);
				drxz_q <= txz + $signed({1'b0, dx_q});
			end else begin
				drxz_q <= txz;
			end
		end
		if (cmd.out_load) begin
			blocked_q <= hit_q;
		end
	end

endmodule

FILE: rtl/voxel_line_occlusion_unit.sv
// voxel line occlusion unit, top level
// depends on vlo_pkg, vlo_ram, vlo_ctrl, vlo_dp and the assertion macro header
//
// input channel (in_valid / in_stall) carries one word per item: action 0 writes
// voxel_value into voxel (voxel_x, voxel_y, voxel_z), coordinates outside the grid
// are dropped; action 1 walks a 3d bresenham line from start to end (end excluded)
// and returns one word on the output channel (out_valid / out_stall) with blocked.
// the occupancy map is a ram of 2^(2*GRID_BITS) rows of 2^GRID_BITS voxels.
// after reset a clearing pass zeroes one row a cycle, all 2^(2*GRID_BITS) rows
// (4096 at the default), with in_stall high throughout.
// a write runs through accept, row read and row write back.
// a query walks at most dx voxels between accept and result, dx being the largest
// axis extent (up to 2^COORD_WIDTH - 1); the walker visits one voxel per cycle
// through the ram read port and stops early at the first solid voxel.
// one item is in work at a time; a finished result sits in the output register,
// and a new item is taken while it waits. if a further query finishes while the
// receiver still stalls, the unit holds in_stall high until the register frees.
`timescale 1ns / 1ps
`include "voxel_line_occlusion_unit_macros.svh"

module voxel_line_occlusion_unit import vlo_pkg::*; #(
	parameter int GRID_BITS   = 6,
	parameter int COORD_WIDTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [VOXEL_W-1:0]            voxel_x,
	input  logic [VOXEL_W-1:0]            voxel_y,
	input  logic [VOXEL_W-1:0]            voxel_z,
	input  logic                          voxel_value,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] start_z,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] end_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          blocked
);

	localparam int SPAN  = 1 << GRID_BITS;
	localparam int ROWS  = 1 << (2 * GRID_BITS);
	localparam int ROW_W = 2 * GRID_BITS;

	vlo_cmd_t         cmd;
	vlo_sts_t         sts;
	logic             ram_we;
	logic [ROW_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_raddr;
	logic [SPAN-1:0]  ram_wdata;
	logic [SPAN-1:0]  ram_rdata;

	vlo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	vlo_dp #(
		.GRID_BITS   (GRID_BITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.voxel_x     (voxel_x),
		.voxel_y     (voxel_y),
		.voxel_z     (voxel_z),
		.voxel_value (voxel_value),
		.start_x     (start_x),
		.start_y     (start_y),
		.start_z     (start_z),
		.end_x       (end_x),
		.end_y       (end_y),
		.end_z       (end_z),
		.blocked     (blocked),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	vlo_ram #(
		.WIDTH (SPAN),
		.DEPTH (ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	`VLO_ASSERT_NXT(a_hit_stops_walk, clk, arst_n, sts.hit_now, !cmd.walk)
	`VLO_ASSERT_IMP(a_wb_after_read, clk, arst_n, cmd.wr_write, $past(cmd.wr_read))
	`VLO_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.out_load, !out_valid || !out_stall)

endmodule

FILE: verif/voxel_line_occlusion_unit_test.sv
// self-checking testbench for voxel_line_occlusion_unit: voxel writes and line queries
// against an in-bench occupancy map and line walker; needs vlo_pkg and the unit's rtl
`timescale 1ns / 1ps

module voxel_line_occlusion_unit_test import vlo_pkg::*; ();

	localparam int GRID_BITS    = 6;
	localparam int COORD_WIDTH  = 8;
	localparam int GRID_SPAN    = 1 << GRID_BITS;
	localparam int MAP_SIZE     = 1 << (3 * GRID_BITS);
	localparam int N_DIRECTED   = 23;
	localparam int N_PRESSURE   = 40;
	localparam int N_RANDOM     = 740;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 300;

	typedef enum logic [1:0] {
		FROM_PREDICTOR = 2'd0,
		READS_CLEAR    = 2'd1,
		READS_BLOCKED  = 2'd2
	} check_t;

	typedef struct packed {
		vlo_action_t            action;
		logic [VOXEL_W-1:0]     vx;
		logic [VOXEL_W-1:0]     vy;
		logic [VOXEL_W-1:0]     vz;
		logic                   vv;
		logic [COORD_WIDTH-1:0] sx;
		logic [COORD_WIDTH-1:0] sy;
		logic [COORD_WIDTH-1:0] sz;
		logic [COORD_WIDTH-1:0] ex;
		logic [COORD_WIDTH-1:0] ey;
		logic [COORD_WIDTH-1:0] ez;
	} voxel_word_t;

	typedef struct packed {
		voxel_word_t w;
		check_t      kind;
	} directed_row_t;

	// fields: action, voxel x/y/z/value, start x/y/z, end x/y/z
	localparam directed_row_t DIRECTED [N_DIRECTED] = '{
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd0, 8'sd0, 8'sd0, 8'sd63, 8'sd63, 8'sd63},
			READS_CLEAR},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd5, 8'sd5, 8'sd5, 8'sd5, 8'sd5, 8'sd5},
			READS_CLEAR},
		'{'{ACT_WRITE, 6'd0, 6'd0, 6'd0, 1'b1, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0},
			FROM_PREDICTOR},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd0, 8'sd0, 8'sd0, 8'sd10, 8'sd0, 8'sd0},
			READS_BLOCKED},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd10, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0},
			FROM_PREDICTOR},
		'{'{ACT_WRITE, 6'd63, 6'd63, 6'd63, 1'b1, -8'sd128, -8'sd128, -8'sd128,
			8'sd127, 8'sd127, 8'sd127}, FROM_PREDICTOR},
		'{'{ACT_QUERY, 6'd63, 6'd63, 6'd63, 1'b1, -8'sd128, -8'sd128, -8'sd128,
			8'sd127, 8'sd127, 8'sd127}, FROM_PREDICTOR},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd127, 8'sd127, 8'sd127,
			-8'sd128, -8'sd128, -8'sd128}, FROM_PREDICTOR},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, -8'sd128, -8'sd128, -8'sd128,
			-8'sd1, -8'sd100, -8'sd50}, READS_CLEAR},
		'{'{ACT_WRITE, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0},
			FROM_PREDICTOR},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd0, 8'sd0, 8'sd0, 8'sd10, 8'sd0, 8'sd0},
			READS_CLEAR},
		'{'{ACT_WRITE, 6'd20, 6'd40, 6'd10, 1'b1, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0},
			FROM_PREDICTOR},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd20, 8'sd0, 8'sd10, 8'sd20, 8'sd63, 8'sd10},
			READS_BLOCKED},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd18, 8'sd38, 8'sd0, 8'sd22, 8'sd42, 8'sd20},
			FROM_PREDICTOR},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd20, 8'sd40, 8'sd63, 8'sd20, 8'sd40, 8'sd0},
			READS_BLOCKED},
		'{'{ACT_WRITE, 6'd63, 6'd0, 6'd0, 1'b1, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0},
			FROM_PREDICTOR},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd127, 8'sd0, 8'sd0, -8'sd128, 8'sd0, 8'sd0},
			FROM_PREDICTOR},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd63, 8'sd63, 8'sd60, 8'sd63, 8'sd63, 8'sd63},
			READS_CLEAR},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd63, 8'sd63, 8'sd63, 8'sd63, 8'sd63, 8'sd60},
			READS_BLOCKED},
		'{'{ACT_QUERY, 6'd63, 6'd63, 6'd63, 1'b1, 8'sd1, 8'sd2, 8'sd3, -8'sd5, 8'sd90, 8'sd7},
			FROM_PREDICTOR},
		'{'{ACT_WRITE, 6'd63, 6'd63, 6'd63, 1'b0, -8'sd1, -8'sd1, -8'sd1, -8'sd1, -8'sd1,
			-8'sd1}, FROM_PREDICTOR},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd63, 8'sd63, 8'sd63, 8'sd63, 8'sd63, 8'sd60},
			READS_CLEAR},
		'{'{ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd127,
			8'sd127}, READS_CLEAR}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic                          action;
	logic [VOXEL_W-1:0]            voxel_x;
	logic [VOXEL_W-1:0]            voxel_y;
	logic [VOXEL_W-1:0]            voxel_z;
	logic                          voxel_value;
	logic signed [COORD_WIDTH-1:0] start_x;
	logic signed [COORD_WIDTH-1:0] start_y;
	logic signed [COORD_WIDTH-1:0] start_z;
	logic signed [COORD_WIDTH-1:0] end_x;
	logic signed [COORD_WIDTH-1:0] end_y;
	logic signed [COORD_WIDTH-1:0] end_z;
	logic                          out_valid;
	logic                          out_stall;
	logic                          blocked;

	bit                        solid_map [0:MAP_SIZE-1];
	logic [3*VOXEL_W-1:0]      solid_spots [$];
	logic                      pending_blocked [$];
	bit                        hold_req;
	bit                        quiet;
	int                        mismatches;
	int                        writes_sent;
	int                        queries_sent;
	int                        results_seen;
	int                        hits_seen;

	voxel_line_occlusion_unit #(
		.GRID_BITS  (GRID_BITS),
		.COORD_WIDTH(COORD_WIDTH)
	) u_dut (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic note_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic int extent(int d);
		return (d < 0) ? -d : d;
	endfunction

	function automatic bit voxel_solid(int x, int y, int z);
		if (x < 0 || y < 0 || z < 0 || x >= GRID_SPAN || y >= GRID_SPAN || z >= GRID_SPAN)
			return 1'b0;
		return solid_map[{z[GRID_BITS-1:0], y[GRID_BITS-1:0], x[GRID_BITS-1:0]}];
	endfunction

	// 3d bresenham walk, major axis swapped into x, end point excluded
	function automatic bit line_blocked(int ax, int ay, int az, int bx, int by, int bz);
		bit swap_xy, swap_xz;
		int t, dx, dy, dz, drift_y, drift_z, step_x, step_y, step_z;
		int x, y, z, cx, cy, cz;
		swap_xy = extent(by - ay) > extent(bx - ax);
		if (swap_xy) begin
			t = ax; ax = ay; ay = t;
			t = bx; bx = by; by = t;
		end
		swap_xz = extent(bz - az) > extent(bx - ax);
		if (swap_xz) begin
			t = ax; ax = az; az = t;
			t = bx; bx = bz; bz = t;
		end
		dx = extent(bx - ax);
		dy = extent(by - ay);
		dz = extent(bz - az);
		drift_y = dx / 2;
		drift_z = dx / 2;
		step_x = (ax > bx) ? -1 : 1;
		step_y = (ay > by) ? -1 : 1;
		step_z = (az > bz) ? -1 : 1;
		y = ay;
		z = az;
		for (x = ax; x != bx; x += step_x) begin
			cx = x; cy = y; cz = z;
			if (swap_xz) begin
				t = cx; cx = cz; cz = t;
			end
			if (swap_xy) begin
				t = cx; cx = cy; cy = t;
			end
			if (voxel_solid(cx, cy, cz))
				return 1'b1;
			drift_y -= dy;
			drift_z -= dz;
			if (drift_y < 0) begin
				y += step_y;
				drift_y += dx;
			end
			if (drift_z < 0) begin
				z += step_z;
				drift_z += dx;
			end
		end
		return 1'b0;
	endfunction

	function automatic voxel_word_t random_word();
		voxel_word_t          w;
		logic [95:0]          noise;
		logic [3*VOXEL_W-1:0] spot;
		int                   pick;
		noise = {$urandom(), $urandom(), $urandom()};
		w = noise[$bits(voxel_word_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			w.action = ACT_WRITE;
			// most writes land in a central cube so that lines run into them
			if ($urandom_range(0, 99) < 70) begin
				w.vx = VOXEL_W'($urandom_range(16, 47));
				w.vy = VOXEL_W'($urandom_range(16, 47));
				w.vz = VOXEL_W'($urandom_range(16, 47));
			end
			w.vv = ($urandom_range(0, 99) < 75);
			return w;
		end
		w.action = ACT_QUERY;
		if (pick < 58 && solid_spots.size() != 0) begin
			spot = solid_spots[$urandom_range(0, solid_spots.size() - 1)];
			w.sx = COORD_WIDTH'(spot[VOXEL_W-1:0]);
			w.sy = COORD_WIDTH'(spot[2*VOXEL_W-1:VOXEL_W]);
			w.sz = COORD_WIDTH'(spot[3*VOXEL_W-1:2*VOXEL_W]);
			w.ex = COORD_WIDTH'(int'(spot[VOXEL_W-1:0]) + int'($urandom_range(0, 40)) - 20);
			w.ey = COORD_WIDTH'(int'(spot[2*VOXEL_W-1:VOXEL_W]) +
				int'($urandom_range(0, 40)) - 20);
			w.ez = COORD_WIDTH'(int'(spot[3*VOXEL_W-1:2*VOXEL_W]) +
				int'($urandom_range(0, 40)) - 20);
		end else if (pick < 64) begin
			w.ex = w.sx;
			w.ey = w.sy;
			w.ez = w.sz;
		end else if (pick >= 74) begin
			w.sx = COORD_WIDTH'(int'($urandom_range(0, 79)) - 8);
			w.sy = COORD_WIDTH'(int'($urandom_range(0, 79)) - 8);
			w.sz = COORD_WIDTH'(int'($urandom_range(0, 79)) - 8);
			w.ex = COORD_WIDTH'(int'($urandom_range(0, 79)) - 8);
			w.ey = COORD_WIDTH'(int'($urandom_range(0, 79)) - 8);
			w.ez = COORD_WIDTH'(int'($urandom_range(0, 79)) - 8);
		end
		return w;
	endfunction

	// offer one word, wait for the handshake, then update the map or queue the answer
	task automatic send_word(input voxel_word_t w, input check_t kind);
		in_valid    <= 1'b1;
		action      <= w.action;
		voxel_x     <= w.vx;
		voxel_y     <= w.vy;
		voxel_z     <= w.vz;
		voxel_value <= w.vv;
		start_x     <= w.sx;
		start_y     <= w.sy;
		start_z     <= w.sz;
		end_x       <= w.ex;
		end_y       <= w.ey;
		end_z       <= w.ez;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		if (w.action == ACT_WRITE) begin
			solid_map[{w.vz, w.vy, w.vx}] = w.vv;
			if (w.vv)
				solid_spots.insert(solid_spots.size(), {w.vz, w.vy, w.vx});
			writes_sent++;
		end else begin
			case (kind)
				READS_CLEAR: begin
					pending_blocked.insert(pending_blocked.size(), 1'b0);
				end
				READS_BLOCKED: begin
					pending_blocked.insert(pending_blocked.size(), 1'b1);
				end
				default: begin
					pending_blocked.insert(pending_blocked.size(), line_blocked(
						int'($signed(w.sx)), int'($signed(w.sy)), int'($signed(w.sz)),
						int'($signed(w.ex)), int'($signed(w.ey)), int'($signed(w.ez))));
				end
			endcase
			queries_sent++;
		end
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_blocked.size() != 0);
	endtask

	initial begin : stimulus
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		action      <= ACT_WRITE;
		voxel_x     <= '0;
		voxel_y     <= '0;
		voxel_z     <= '0;
		voxel_value <= 1'b0;
		start_x     <= '0;
		start_y     <= '0;
		start_z     <= '0;
		end_x       <= '0;
		end_y       <= '0;
		end_z       <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(DIRECTED[i].w, DIRECTED[i].kind);
		wait_all_results();

		// receiver holds off while words keep coming, so the unit backs up
		quiet = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < N_PRESSURE; i++)
			send_word(random_word(), FROM_PREDICTOR);
		wait_all_results();

		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = (i >= 300 && i < 420);
			if (i == 500)
				wait_all_results();
			send_word(random_word(), FROM_PREDICTOR);
			if (!quiet && $urandom_range(0, 99) < 9) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
		quiet = 1'b0;

		for (int c = 0; c < DRAIN_LIMIT && pending_blocked.size() != 0; c++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_blocked.size() != 0)
			note_mismatch($sformatf("%0d query results never arrived", pending_blocked.size()));

		$display("covered %0d voxel writes and %0d line queries", writes_sent, queries_sent);
		$display("checked %0d results, %0d of them blocked", results_seen, hits_seen);
		if (mismatches == 0)
			$display("voxel_line_occlusion_unit regression: pass");
		else
			$display("voxel_line_occlusion_unit regression: fail");
		$finish;
	end

	initial begin : result_side
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= !quiet && ($urandom_range(0, 99) < 9);
			end
		end
	end

	always @(posedge clk) begin : result_check
		logic want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_blocked.size() == 0) begin
				note_mismatch("result word with no query waiting");
			end else begin
				want = pending_blocked.pop_front();
				results_seen++;
				if (blocked === 1'b1)
					hits_seen++;
				if (blocked !== want)
					note_mismatch($sformatf("blocked %b, expected %b", blocked, want));
			end
		end
	end

	initial begin : watchdog
		#20_000_000;
		$display("voxel_line_occlusion_unit regression: fail");
		$finish;
	end

endmodule
